// ===== rtl/core/stok_pkg.sv =====
// ---------------------------------------------------------------------------
// stok_pkg
// Shared types and constants of the source tokenizer.
// ---------------------------------------------------------------------------
package stok_pkg;

  // Scan state of the pending token
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_BADID  = 3'd3,
    MODE_EQ     = 3'd4,
    MODE_LT     = 3'd5,
    MODE_GT     = 3'd6,
    MODE_BANG   = 3'd7
  } mode_t;

  // Token classes
  localparam logic [3:0] CLS_RESERVED = 4'd0;
  localparam logic [3:0] CLS_ID       = 4'd1;
  localparam logic [3:0] CLS_NUM      = 4'd2;
  localparam logic [3:0] CLS_COP      = 4'd3;
  localparam logic [3:0] CLS_AOP      = 4'd4;
  localparam logic [3:0] CLS_OOP      = 4'd5;
  localparam logic [3:0] CLS_EOP      = 4'd6;
  localparam logic [3:0] CLS_SOP      = 4'd7;
  localparam logic [3:0] CLS_BADID    = 4'd8;
  localparam logic [3:0] CLS_UNKNOWN  = 4'd9;

  // Characters
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;

  localparam logic [15:0] LINE_FIRST = 16'd1;
  localparam logic [15:0] POS_MAX    = 16'hFFFF;
  localparam logic [7:0]  LEN_MAX    = 8'hFF;

  // Configuration port
  localparam int CFG_IDX_W = 3;

  // Result queue
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW    = 3;

  typedef struct packed {
    logic [3:0]  token_class;
    logic [63:0] lexeme_bytes;
    logic [7:0]  lexeme_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;
  } result_t;

  // Up to two results written per item
  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== rtl/core/stok_scan.sv =====
// ---------------------------------------------------------------------------
// stok_scan
// Scan state, keyword registers and per-item token logic.
// ---------------------------------------------------------------------------
module stok_scan #(
  parameter int KEYWORD_COUNT = 6,
  parameter int LEXEME_BYTES  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic [7:0]                    item_byte,
  input  logic                          item_end,
  input  logic                          cfg_we,
  input  logic [stok_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  output stok_pkg::push_t               push
);

  localparam int LW = 8 * LEXEME_BYTES;

  stok_pkg::mode_t mode, mode_next;
  logic [LW-1:0] store, store_next, take_store;
  logic [7:0]    count, count_next, count_inc;
  logic [15:0]   line, line_next, line_bump;
  logic [15:0]   col, col_next, col_bump;
  logic [15:0]   start, start_next;
  logic [63:0]   kw [KEYWORD_COUNT];

  logic c_alpha, c_digit, c_space, c_nl, c_eq, c_lt, c_gt, c_bang;
  logic take_v, flush_v, cop_v, idle_v, single_v, reserved;
  logic [3:0] pend_cls, single_cls;
  stok_pkg::result_t pend_res, cop_res, single_res;

  // Character decode
  always_comb begin
    c_alpha = (item_byte inside {[stok_pkg::CH_LOW_A:stok_pkg::CH_LOW_Z],
                                 [stok_pkg::CH_UP_A:stok_pkg::CH_UP_Z]});
    c_digit = (item_byte inside {[stok_pkg::CH_DIG_0:stok_pkg::CH_DIG_9]});
    c_space = (item_byte == stok_pkg::CH_SPACE);
    c_nl    = (item_byte == stok_pkg::CH_NL);
    c_eq    = (item_byte == stok_pkg::CH_EQ);
    c_lt    = (item_byte == stok_pkg::CH_LT);
    c_gt    = (item_byte == stok_pkg::CH_GT);
    c_bang  = (item_byte == stok_pkg::CH_BANG);
  end

  // What this item does: extend, close the pending token, or start afresh
  always_comb begin
    take_v  = 1'b0;
    flush_v = 1'b0;
    cop_v   = 1'b0;
    idle_v  = 1'b0;
    if (item_valid) begin
      if (item_end) begin
        flush_v = (mode != stok_pkg::MODE_IDLE);
      end else begin
        case (mode)
          stok_pkg::MODE_IDENT, stok_pkg::MODE_BADID, stok_pkg::MODE_NUMBER: begin
            if (c_digit || c_alpha) begin
              take_v = 1'b1;
            end else begin
              flush_v = 1'b1;
              idle_v  = 1'b1;
            end
          end
          stok_pkg::MODE_EQ, stok_pkg::MODE_LT, stok_pkg::MODE_GT,
          stok_pkg::MODE_BANG: begin
            if (c_eq) begin
              cop_v = 1'b1;
            end else begin
              flush_v = 1'b1;
              idle_v  = 1'b1;
            end
          end
          default: begin
            idle_v = 1'b1;
          end
        endcase
      end
    end
  end

  // Next scan state
  always_comb begin
    mode_next = mode;
    if (item_valid) begin
      if (item_end || cop_v) begin
        mode_next = stok_pkg::MODE_IDLE;
      end else if (take_v) begin
        if (mode == stok_pkg::MODE_NUMBER && c_alpha) begin
          mode_next = stok_pkg::MODE_BADID;
        end
      end else if (idle_v) begin
        if (c_alpha) begin
          mode_next = stok_pkg::MODE_IDENT;
        end else if (c_digit) begin
          mode_next = stok_pkg::MODE_NUMBER;
        end else if (c_eq) begin
          mode_next = stok_pkg::MODE_EQ;
        end else if (c_lt) begin
          mode_next = stok_pkg::MODE_LT;
        end else if (c_gt) begin
          mode_next = stok_pkg::MODE_GT;
        end else if (c_bang) begin
          mode_next = stok_pkg::MODE_BANG;
        end else begin
          mode_next = stok_pkg::MODE_IDLE;
        end
      end
    end
  end

  // Position, lexeme and results
  always_comb begin
    count_inc = (count != stok_pkg::LEN_MAX) ? count + 8'd1 : count;
    col_bump  = (col != stok_pkg::POS_MAX) ? col + 16'd1 : col;
    line_bump = (line != stok_pkg::POS_MAX) ? line + 16'd1 : line;

    for (int i = 0; i < LEXEME_BYTES; i++) begin
      take_store[8*i +: 8] = (count == 8'(i)) ? item_byte : store[8*i +: 8];
    end

    store_next = store;
    count_next = count;
    line_next  = line;
    col_next   = col;
    start_next = start;

    if (item_valid && item_end) begin
      line_next = stok_pkg::LINE_FIRST;
      col_next  = '0;
    end
    if (take_v || cop_v) begin
      store_next = take_store;
      count_next = count_inc;
      col_next   = col_bump;
    end
    if (idle_v) begin
      if (c_space) begin
        col_next = col_bump;
      end else if (c_nl) begin
        line_next = line_bump;
        col_next  = '0;
      end else begin
        store_next = LW'(item_byte);
        count_next = 8'd1;
        start_next = col;
        col_next   = col_bump;
      end
    end

    single_v = idle_v && !(c_alpha || c_digit || c_space || c_nl ||
                           c_eq || c_lt || c_gt || c_bang);
    if (item_byte inside {stok_pkg::CH_PLUS, stok_pkg::CH_MINUS,
                          stok_pkg::CH_SLASH, stok_pkg::CH_STAR}) begin
      single_cls = stok_pkg::CLS_OOP;
    end else if (item_byte == stok_pkg::CH_SEMI) begin
      single_cls = stok_pkg::CLS_EOP;
    end else if (item_byte inside {stok_pkg::CH_LPAREN, stok_pkg::CH_RPAREN,
                                   stok_pkg::CH_COMMA, stok_pkg::CH_LBRACK,
                                   stok_pkg::CH_RBRACK, stok_pkg::CH_LBRACE,
                                   stok_pkg::CH_RBRACE}) begin
      single_cls = stok_pkg::CLS_SOP;
    end else begin
      single_cls = stok_pkg::CLS_UNKNOWN;
    end

    // Reserved words only match lexemes that fit the store entirely
    reserved = 1'b0;
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      if (kw[k] != '0 && kw[k] == 64'(store)) begin
        reserved = 1'b1;
      end
    end
    if (count > 8'(LEXEME_BYTES)) begin
      reserved = 1'b0;
    end

    case (mode)
      stok_pkg::MODE_IDENT:  pend_cls = reserved ? stok_pkg::CLS_RESERVED : stok_pkg::CLS_ID;
      stok_pkg::MODE_NUMBER: pend_cls = stok_pkg::CLS_NUM;
      stok_pkg::MODE_BADID:  pend_cls = stok_pkg::CLS_BADID;
      stok_pkg::MODE_EQ:     pend_cls = stok_pkg::CLS_AOP;
      default:               pend_cls = stok_pkg::CLS_COP;
    endcase

    pend_res.token_class   = pend_cls;
    pend_res.lexeme_bytes  = 64'(store);
    pend_res.lexeme_length = count;
    pend_res.line_number   = line;
    pend_res.column_number = start;
    pend_res.last_of_run   = !single_v;

    // two-character comparison keeps the column of its first character
    cop_res.token_class   = stok_pkg::CLS_COP;
    cop_res.lexeme_bytes  = 64'(take_store);
    cop_res.lexeme_length = count_inc;
    cop_res.line_number   = line;
    cop_res.column_number = start;
    cop_res.last_of_run   = 1'b1;

    single_res.token_class   = single_cls;
    single_res.lexeme_bytes  = 64'(item_byte);
    single_res.lexeme_length = 8'd1;
    single_res.line_number   = line;
    single_res.column_number = col;
    single_res.last_of_run   = 1'b1;

    push.n      = {1'b0, flush_v} + {1'b0, cop_v} + {1'b0, single_v};
    push.first  = flush_v ? pend_res : (cop_v ? cop_res : single_res);
    push.second = single_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= stok_pkg::MODE_IDLE;
      store <= '0;
      count <= '0;
      line  <= stok_pkg::LINE_FIRST;
      col   <= '0;
      start <= '0;
    end else begin
      mode  <= mode_next;
      store <= store_next;
      count <= count_next;
      line  <= line_next;
      col   <= col_next;
      start <= start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
        kw[k] <= '0;
      end
    end else begin
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
        if (cfg_we && cfg_index == stok_pkg::CFG_IDX_W'(k)) begin
          kw[k] <= cfg_data;
        end
      end
    end
  end

endmodule

// ===== rtl/core/stok_queue.sv =====
// ---------------------------------------------------------------------------
// stok_queue
// Result queue: up to two writes per cycle, one read toward the output.
// ---------------------------------------------------------------------------
module stok_queue (
  input  logic              clk,
  input  logic              rst,
  input  stok_pkg::push_t   push,
  input  logic              hold_in,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output stok_pkg::result_t out_res
);

  localparam int AW = stok_pkg::QUEUE_AW;
  localparam int CW = stok_pkg::QUEUE_AW + 2;

  stok_pkg::result_t mem [stok_pkg::QUEUE_DEPTH];
  logic [AW-1:0] head, tail;
  logic [AW:0]   count;
  logic          pop;
  logic [CW-1:0] need;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign out_res   = mem[head];

  // room for the item in flight plus one more, two results each
  assign need = CW'(count) + (hold_in ? CW'(2) : CW'(0)) + CW'(2);
  assign busy = (need > CW'(stok_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + AW'(pop);
      tail  <= tail + AW'(push.n);
      count <= count + (AW+1)'(push.n) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[tail] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem[tail + AW'(1)] <= push.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> (CW'(count) + CW'(push.n)) <= CW'(stok_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_pair_marks: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> (push.second.last_of_run && !push.first.last_of_run))
    else $error("two-token item marked wrong");

  a_single_mark: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd1 |-> push.first.last_of_run)
    else $error("single token not marked last");

  a_write_shows: assert property (@(posedge clk) disable iff (rst)
    (count == '0 && push.n != 2'd0) |=> out_valid)
    else $error("written result not presented");

endmodule

// ===== rtl/core/source_tokenizer_unit.sv =====
// ---------------------------------------------------------------------------
// source_tokenizer_unit
// Streaming tokenizer: one source byte per item in, tokens out.
// ---------------------------------------------------------------------------
// Takes one text byte per cycle while in_stall is low. An accepted item is
// registered, then the scan logic classifies it and writes zero, one or two
// tokens into an 8-entry result queue; a token reaches the output once its
// closing byte has passed the item register and been written to the queue.
// Input throughput is one item per cycle while in_stall is low; the output
// port moves one token per cycle while out_stall is low, so a run of items
// that each close two tokens is limited by the output. in_stall rises when
// the queue has no room for two tokens from the registered item plus two
// from a new one. Keyword registers are to be written through the cfg port
// (always ready) only while the block is idle; the block does not enforce it.
module source_tokenizer_unit #(
  parameter int KEYWORD_COUNT = 6,
  parameter int LEXEME_BYTES  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    text_byte,
  input  logic                          end_of_text,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    token_class,
  output logic [63:0]                   lexeme_bytes,
  output logic [7:0]                    lexeme_length,
  output logic [15:0]                   line_number,
  output logic [15:0]                   column_number,
  output logic                          last_of_run,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [stok_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);

  logic              item_valid;
  logic [7:0]        item_byte;
  logic              item_end;
  logic              busy;
  stok_pkg::push_t   push;
  stok_pkg::result_t head_res;

  assign in_stall  = busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_byte <= text_byte;
      item_end  <= end_of_text;
    end
  end

  stok_scan #(
    .KEYWORD_COUNT(KEYWORD_COUNT),
    .LEXEME_BYTES (LEXEME_BYTES)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_byte (item_byte),
    .item_end  (item_end),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push)
  );

  stok_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .hold_in  (item_valid),
    .busy     (busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (head_res)
  );

  assign token_class   = head_res.token_class;
  assign lexeme_bytes  = head_res.lexeme_bytes;
  assign lexeme_length = head_res.lexeme_length;
  assign line_number   = head_res.line_number;
  assign column_number = head_res.column_number;
  assign last_of_run   = head_res.last_of_run;

endmodule
